>>> hw/rtl/slac_matching_evse_fsm_core_macros.svh
// Assertion macros shared by the link-matching sequencer RTL.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef SLAC_MATCHING_EVSE_FSM_CORE_MACROS_SVH
`define SLAC_MATCHING_EVSE_FSM_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define SMEF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define SMEF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/smef_pkg.sv
// Types, codes and widths for the link-matching sequencer.
// No dependencies.
package smef_pkg;

	// field and register widths
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int MSG_W          = 3;
	localparam int CODE_W         = 4;
	localparam int TIMER_BITS_DEF = 16;

	// register reset values
	localparam logic [CFG_W-1:0] TOTAL_TIMEOUT_RST = 16'd60000;
	localparam logic [CFG_W-1:0] SOUND_WINDOW_RST  = 16'd1500;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SOUND_WINDOW  = 1'b1;

	// received message kinds
	localparam logic [MSG_W-1:0] MSG_SWVER    = 3'd1;
	localparam logic [MSG_W-1:0] MSG_PARAM    = 3'd2;
	localparam logic [MSG_W-1:0] MSG_STARTATT = 3'd3;
	localparam logic [MSG_W-1:0] MSG_ATTCHAR  = 3'd4;
	localparam logic [MSG_W-1:0] MSG_MATCH    = 3'd5;
	localparam logic [MSG_W-1:0] MSG_SETKEY   = 3'd6;

	// reported state codes
	localparam logic [CODE_W-1:0] CODE_GETVER   = 4'd0;
	localparam logic [CODE_W-1:0] CODE_IDLE     = 4'd1;
	localparam logic [CODE_W-1:0] CODE_ESTAB    = 4'd2;
	localparam logic [CODE_W-1:0] CODE_STARTATT = 4'd3;
	localparam logic [CODE_W-1:0] CODE_SOUND    = 4'd4;
	localparam logic [CODE_W-1:0] CODE_ATTCHAR  = 4'd5;
	localparam logic [CODE_W-1:0] CODE_MATCH    = 4'd6;
	localparam logic [CODE_W-1:0] CODE_SETKEY   = 4'd7;
	localparam logic [CODE_W-1:0] CODE_MATCHED  = 4'd8;
	localparam logic [CODE_W-1:0] CODE_FAILED   = 4'd9;

	// protocol state, one-hot
	typedef enum logic [9:0] {
		ST_GETVER   = 10'b00_0000_0001,
		ST_IDLE     = 10'b00_0000_0010,
		ST_ESTAB    = 10'b00_0000_0100,
		ST_STARTATT = 10'b00_0000_1000,
		ST_SOUND    = 10'b00_0001_0000,
		ST_ATTCHAR  = 10'b00_0010_0000,
		ST_MATCH    = 10'b00_0100_0000,
		ST_SETKEY   = 10'b00_1000_0000,
		ST_MATCHED  = 10'b01_0000_0000,
		ST_FAILED   = 10'b10_0000_0000
	} state_t;

	// map a state to its reported code
	function automatic logic [CODE_W-1:0] code_of(state_t st);
		logic [CODE_W-1:0] code;
		unique case (st)
			ST_GETVER:   code = CODE_GETVER;
			ST_IDLE:     code = CODE_IDLE;
			ST_ESTAB:    code = CODE_ESTAB;
			ST_STARTATT: code = CODE_STARTATT;
			ST_SOUND:    code = CODE_SOUND;
			ST_ATTCHAR:  code = CODE_ATTCHAR;
			ST_MATCH:    code = CODE_MATCH;
			ST_SETKEY:   code = CODE_SETKEY;
			ST_MATCHED:  code = CODE_MATCHED;
			ST_FAILED:   code = CODE_FAILED;
			default:     code = CODE_GETVER;
		endcase
		return code;
	endfunction

endpackage

>>> hw/rtl/slac_matching_evse_fsm_core.sv
// Charger-side link-matching sequencer: protocol state, timers, result register.
// Depends on smef_pkg and slac_matching_evse_fsm_core_macros.svh.
//
// One polling step is taken per clock cycle while the output register is
// free or draining. A step is transferred on the input channel, runs through
// the state and timer logic in the same cycle and its result sits in the
// output register from the next cycle on. The single output register sets the
// rate: in_ready is high whenever that register is empty or being drained in
// the same cycle. Configuration writes are always taken and only affect the
// next counter reloads.
`include "slac_matching_evse_fsm_core_macros.svh"

module slac_matching_evse_fsm_core #(
	parameter int TIMER_BITS = smef_pkg::TIMER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [smef_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smef_pkg::CFG_W-1:0]      cfg_data,
	// polling step channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            start_req,
	input  logic [smef_pkg::MSG_W-1:0]      msg_kind,
	input  logic                            sounds_done,
	input  logic                            key_ok,
	input  logic                            ms_tick,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [smef_pkg::CODE_W-1:0]     fsm_code,
	output logic                            done_flag,
	output logic                            send_version_req,
	output logic                            clear_stack,
	output logic                            send_param_cnf,
	output logic                            send_atten_ind,
	output logic                            send_match_and_key,
	output logic                            timeout_fail,
	output logic                            sound_cut
);
	import smef_pkg::*;

	logic [CFG_W-1:0]      total_timeout_q;
	logic [CFG_W-1:0]      sound_window_q;
	state_t                state_q;
	logic                  just_entered_q;
	logic [TIMER_BITS-1:0] overall_left_q;
	logic [TIMER_BITS-1:0] sound_left_q;
	logic                  out_valid_q;

	logic                  in_xfer;
	logic                  guarded;
	logic [TIMER_BITS-1:0] ov_cnt;
	logic [TIMER_BITS-1:0] snd_cnt;
	logic [TIMER_BITS-1:0] ov_nxt;
	logic [TIMER_BITS-1:0] snd_nxt;
	state_t                nxt;
	logic                  ver;
	logic                  clr;
	logic                  pcnf;
	logic                  aind;
	logic                  mkey;
	logic                  tfail;
	logic                  cut;
	logic                  done_c;

	// take a new step when the result register is free or draining
	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_timeout_q <= TOTAL_TIMEOUT_RST;
			sound_window_q  <= SOUND_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOTAL_TIMEOUT: total_timeout_q <= cfg_data;
				REG_SOUND_WINDOW:  sound_window_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// step logic: count down on tick, then timeout test and state actions
	always_comb begin
		ov_cnt  = (ms_tick && overall_left_q != '0) ? overall_left_q - 1'b1 : overall_left_q;
		snd_cnt = (ms_tick && sound_left_q != '0) ? sound_left_q - 1'b1 : sound_left_q;
		ov_nxt  = ov_cnt;
		snd_nxt = snd_cnt;
		nxt     = state_q;
		ver     = 1'b0;
		clr     = 1'b0;
		pcnf    = 1'b0;
		aind    = 1'b0;
		mkey    = 1'b0;
		tfail   = 1'b0;
		cut     = 1'b0;
		done_c  = (state_q == ST_MATCHED) || (state_q == ST_FAILED);
		guarded = (state_q == ST_STARTATT) || (state_q == ST_SOUND) ||
			(state_q == ST_ATTCHAR) || (state_q == ST_MATCH) || (state_q == ST_SETKEY);

		if (guarded && ov_cnt == '0) begin
			nxt   = ST_FAILED;
			tfail = 1'b1;
		end else begin
			unique case (state_q)
				ST_GETVER: begin
					ver = just_entered_q;
					if (msg_kind == MSG_SWVER) nxt = ST_IDLE;
				end
				ST_IDLE: begin
					clr = just_entered_q;
					if (start_req) begin
						ov_nxt = TIMER_BITS'(total_timeout_q);
						nxt    = ST_ESTAB;
					end
				end
				ST_ESTAB: begin
					if (msg_kind == MSG_PARAM) begin
						pcnf   = 1'b1;
						ov_nxt = TIMER_BITS'(total_timeout_q);
						nxt    = ST_STARTATT;
					end
				end
				ST_STARTATT: begin
					if (msg_kind == MSG_STARTATT) nxt = ST_SOUND;
				end
				ST_SOUND: begin
					// load the window on entry and test it in the same step
					if (just_entered_q) snd_nxt = TIMER_BITS'(sound_window_q);
					if (sounds_done) begin
						aind = 1'b1;
						nxt  = ST_ATTCHAR;
					end else if (snd_nxt == '0) begin
						aind = 1'b1;
						cut  = 1'b1;
						nxt  = ST_ATTCHAR;
					end
				end
				ST_ATTCHAR: begin
					if (msg_kind == MSG_ATTCHAR) nxt = ST_MATCH;
				end
				ST_MATCH: begin
					if (msg_kind == MSG_MATCH) begin
						mkey = 1'b1;
						nxt  = ST_SETKEY;
					end
				end
				ST_SETKEY: begin
					if (msg_kind == MSG_SETKEY) nxt = key_ok ? ST_MATCHED : ST_ESTAB;
				end
				ST_MATCHED, ST_FAILED: begin
					if (!start_req) nxt = ST_IDLE;
				end
				default: nxt = ST_GETVER;
			endcase
		end
	end

	// protocol state and timers advance on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_GETVER;
			just_entered_q <= 1'b1;
			overall_left_q <= TIMER_BITS'(TOTAL_TIMEOUT_RST);
			sound_left_q   <= '0;
		end else if (in_xfer) begin
			state_q        <= nxt;
			just_entered_q <= (nxt != state_q);
			overall_left_q <= ov_nxt;
			sound_left_q   <= snd_nxt;
		end
	end

	// result valid: set on input transfer, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, held until the next input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fsm_code           <= code_of(nxt);
			done_flag          <= done_c;
			send_version_req   <= ver;
			clear_stack        <= clr;
			send_param_cnf     <= pcnf;
			send_atten_ind     <= aind;
			send_match_and_key <= mkey;
			timeout_fail       <= tfail;
			sound_cut          <= cut;
		end
	end

	`SMEF_ASSERT(a_xfer_fills_out, (in_valid && in_ready) |=> out_valid, "result register not filled after input transfer")
	`SMEF_ASSERT(a_stall_blocks_in, (out_valid && !out_ready) |-> !in_ready, "input taken while result stalled")
	`SMEF_ASSERT(a_tfail_state, (out_valid && timeout_fail) |-> (fsm_code == CODE_FAILED), "timeout without failed state")
	`SMEF_ASSERT(a_cut_reports, (out_valid && sound_cut) |-> (send_atten_ind && fsm_code == CODE_ATTCHAR), "sound cut without attenuation report")
	`SMEF_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result valid during reset")

endmodule
